// ===== hdl/lzss_rle_stream_decoder_defines.svh =====
// Assertion macros for the stream decoder checker
`ifndef LZSS_RLE_STREAM_DECODER_DEFINES_SVH
`define LZSS_RLE_STREAM_DECODER_DEFINES_SVH
// Implication checked every clock outside reset
`define LRD_ASSERT_IMP(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// Next-cycle implication
`define LRD_ASSERT_NXT(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

// ===== hdl/lrd_pkg.sv =====
// Shared types and constants for the stream decoder
package lrd_pkg;
    localparam int MaxWindowBits = 16;

    typedef enum logic [2:0] {
        ST_BYTE = 3'd0, ST_NEED = 3'd1, ST_END = 3'd2, ST_HDR_ERR = 3'd3,
        ST_FEED_OK = 3'd4, ST_FEED_REJ = 3'd5
    } t_status;

    localparam logic OP_FEED = 1'b0;
    localparam logic OP_PULL = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] in_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] status;
    } t_out;

    // Controller -> datapath commands
    typedef enum logic [3:0] {
        C_IDLE, C_FEED, C_SHIFT, C_FINISH, C_REP, C_COPY_RD, C_COPY_WR, C_COPY_DONE
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op    op;
        logic [7:0] feed_byte;
    } t_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic rep_pending;
        logic ended;
        logic errored;
        logic in_copy;
        logic copy_zero;
        logic field_pending;
        logic buf_empty;
        logic [7:0] rep_value;
    } t_stat;
endpackage

// ===== hdl/lrd_datapath.sv =====
// Bit reader, token decoder state, history window and RLE expander
module lrd_datapath #(
    parameter int MAX_WINDOW_BITS = lrd_pkg::MaxWindowBits
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  lrd_pkg::t_cmd i_cmd,
    output lrd_pkg::t_stat o_stat
);
    import lrd_pkg::*;

    localparam int Aw = MAX_WINDOW_BITS;
    localparam int Depth = 1 << Aw;

    typedef enum logic [3:0] {
        PH_HDR_W, PH_HDR_L, PH_FLAG, PH_LIT, PH_OFF_A, PH_OFF_B,
        PH_LEN_A, PH_LEN_B, PH_COPY, PH_END, PH_ERR
    } t_phase;

    typedef enum logic [1:0] {RLE_DEFINE, RLE_NORMAL, RLE_COUNT, RLE_VALUE} t_rle;

    logic [7:0]  r_buf;
    logic [3:0]  r_bits_left;
    t_phase      r_phase;
    logic [16:0] r_acc;
    logic [4:0]  r_fbits;
    logic [4:0]  r_wexp;
    logic [3:0]  r_lexp;
    logic [Aw-1:0] r_wpos, r_csrc;
    logic [16:0] r_crem;
    logic [7:0]  r_esc;
    t_rle        r_rle;
    logic [8:0]  r_pend, r_rrem;
    logic [7:0]  r_rval;
    logic [7:0]  mem [Depth];
    logic [7:0]  r_rd;

    logic [16:0] wmask, lsize, wsize;
    logic [16:0] off;
    logic [16:0] src_sum;
    logic        store_en;
    logic [7:0]  store_b;
    logic [8:0]  cnt;

    assign wmask = (17'd1 << r_wexp) - 17'd1;
    assign wsize = 17'd1 << r_wexp;
    assign lsize = 17'd1 << r_lexp;
    assign off   = (r_phase == PH_OFF_A) ? r_acc : (r_acc + 17'd1 - lsize);
    assign src_sum = ({1'b0, 16'(r_wpos)} + ((wsize - off - 17'd1) & wmask)) & wmask;
    assign cnt = (store_b == 8'd0) ? 9'h100 : {1'b0, store_b};

    always_comb begin
        store_en = 1'b0;
        store_b  = r_acc[7:0];
        if (i_cmd.op == C_FINISH && r_phase == PH_LIT) store_en = 1'b1;
        if (i_cmd.op == C_COPY_WR) begin
            store_en = 1'b1;
            store_b  = r_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == C_COPY_RD) r_rd <= mem[r_csrc];
        if (store_en) mem[r_wpos] <= store_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf <= '0; r_bits_left <= '0; r_phase <= PH_HDR_W; r_acc <= '0;
            r_fbits <= 5'd5; r_wexp <= '0; r_lexp <= '0; r_wpos <= '0; r_csrc <= '0;
            r_crem <= '0; r_esc <= '0; r_rle <= RLE_DEFINE; r_pend <= '0;
            r_rrem <= '0; r_rval <= '0;
        end else begin
            case (i_cmd.op)
                C_FEED: begin
                    r_buf <= i_cmd.feed_byte;
                    r_bits_left <= 4'd8;
                end
                C_SHIFT: begin
                    r_acc <= {r_acc[15:0], r_buf[7]};
                    r_buf <= {r_buf[6:0], 1'b0};
                    r_bits_left <= r_bits_left - 4'd1;
                    r_fbits <= r_fbits - 5'd1;
                end
                C_REP: r_rrem <= r_rrem - 9'd1;
                C_COPY_RD: begin
                    r_csrc <= Aw'((r_csrc + 1'b1) & wmask[Aw-1:0]);
                    r_crem <= r_crem - 17'd1;
                end
                C_COPY_DONE: begin
                    r_phase <= PH_FLAG; r_acc <= '0; r_fbits <= 5'd1;
                end
                C_FINISH: begin
                    case (r_phase)
                        PH_HDR_W: begin
                            r_wexp <= r_acc[4:0];
                            r_phase <= PH_HDR_L; r_acc <= '0; r_fbits <= 5'd4;
                        end
                        PH_HDR_L: begin
                            r_lexp <= r_acc[3:0];
                            if (r_wexp == 5'd0 || r_wexp > 5'(MAX_WINDOW_BITS)
                                || r_acc[3:0] == 4'd0) begin
                                r_phase <= PH_ERR;
                            end else begin
                                r_phase <= PH_FLAG; r_acc <= '0; r_fbits <= 5'd1;
                            end
                        end
                        PH_FLAG: begin
                            r_acc <= '0;
                            if (r_acc[0]) begin
                                r_phase <= PH_LIT; r_fbits <= 5'd8;
                            end else begin
                                r_phase <= PH_OFF_A; r_fbits <= r_wexp - 5'd1;
                            end
                        end
                        PH_LIT: begin
                            r_phase <= PH_FLAG; r_acc <= '0; r_fbits <= 5'd1;
                        end
                        PH_OFF_A: begin
                            if (r_acc >= lsize - 17'd1) begin
                                r_phase <= PH_OFF_B; r_fbits <= 5'd1;
                            end else begin
                                r_csrc <= src_sum[Aw-1:0];
                                r_phase <= PH_LEN_A; r_acc <= '0;
                                r_fbits <= {1'b0, r_lexp - 4'd1};
                            end
                        end
                        PH_OFF_B: begin
                            if (r_acc == wsize - 17'd1) begin
                                r_phase <= PH_END;
                            end else begin
                                r_csrc <= src_sum[Aw-1:0];
                                r_phase <= PH_LEN_A; r_acc <= '0;
                                r_fbits <= {1'b0, r_lexp - 4'd1};
                            end
                        end
                        PH_LEN_A: begin
                            if (r_acc == 17'd1) begin
                                r_crem <= 17'd2; r_phase <= PH_COPY;
                            end else begin
                                r_phase <= PH_LEN_B; r_fbits <= 5'd1;
                            end
                        end
                        PH_LEN_B: begin
                            if (r_acc == 17'd1) r_crem <= 17'd3;
                            else if (r_acc == 17'd0) r_crem <= lsize;
                            else r_crem <= r_acc;
                            r_phase <= PH_COPY;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase

            if (store_en) begin
                r_wpos <= Aw'((r_wpos + 1'b1) & wmask[Aw-1:0]);
                case (r_rle)
                    RLE_DEFINE: begin
                        r_esc <= store_b; r_rle <= RLE_NORMAL;
                    end
                    RLE_NORMAL: begin
                        if (store_b != r_esc) begin
                            r_rval <= store_b; r_rrem <= 9'd1;
                        end else r_rle <= RLE_COUNT;
                    end
                    RLE_COUNT: begin
                        if (cnt > 9'd3) begin
                            r_pend <= cnt; r_rle <= RLE_VALUE;
                        end else begin
                            r_rval <= r_esc; r_rrem <= cnt; r_rle <= RLE_NORMAL;
                        end
                    end
                    default: begin
                        r_rval <= store_b; r_rrem <= r_pend; r_rle <= RLE_NORMAL;
                    end
                endcase
            end
        end
    end

    assign o_stat.rep_pending   = (r_rrem != 9'd0);
    assign o_stat.ended         = (r_phase == PH_END);
    assign o_stat.errored       = (r_phase == PH_ERR);
    assign o_stat.in_copy       = (r_phase == PH_COPY);
    assign o_stat.copy_zero     = (r_crem == 17'd0);
    assign o_stat.field_pending = (r_fbits != 5'd0);
    assign o_stat.buf_empty     = (r_bits_left == 4'd0);
    assign o_stat.rep_value     = r_rval;
endmodule

// ===== hdl/lrd_ctrl.sv =====
// Request sequencer: answers feeds, runs pulls step by step and drives the result register
module lrd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  lrd_pkg::t_in   i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output lrd_pkg::t_out  o_data,
    output lrd_pkg::t_cmd  o_cmd,
    input  lrd_pkg::t_stat i_stat
);
    import lrd_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_PULL, S_COPY_WR, S_OUT} t_state;

    t_state r_state, n_state;
    t_out   r_out, n_out;
    t_out   r_res, n_res;
    logic   r_ov, n_ov;

    always_comb begin
        n_state = r_state;
        n_out = r_out;
        n_res = r_res;
        n_ov = r_ov;
        o_cmd.op = C_IDLE;
        o_cmd.feed_byte = i_data.in_byte;
        o_ready = 1'b0;
        if (r_ov && i_ready) n_ov = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_data.op == OP_FEED) begin
                        if (i_stat.buf_empty && !i_stat.ended && !i_stat.errored) begin
                            o_cmd.op = C_FEED;
                            n_res = '{out_byte: 8'd0, status: ST_FEED_OK};
                        end else n_res = '{out_byte: 8'd0, status: ST_FEED_REJ};
                        n_state = S_OUT;
                    end else n_state = S_PULL;
                end
            end
            S_PULL: begin
                n_state = S_OUT;
                if (i_stat.rep_pending) begin
                    o_cmd.op = C_REP;
                    n_res = '{out_byte: i_stat.rep_value, status: ST_BYTE};
                end else if (i_stat.ended) begin
                    n_res = '{out_byte: 8'd0, status: ST_END};
                end else if (i_stat.errored) begin
                    n_res = '{out_byte: 8'd0, status: ST_HDR_ERR};
                end else if (i_stat.in_copy) begin
                    n_state = S_PULL;
                    if (i_stat.copy_zero) o_cmd.op = C_COPY_DONE;
                    else begin
                        o_cmd.op = C_COPY_RD;
                        n_state = S_COPY_WR;
                    end
                end else if (i_stat.field_pending) begin
                    if (i_stat.buf_empty) n_res = '{out_byte: 8'd0, status: ST_NEED};
                    else begin
                        o_cmd.op = C_SHIFT;
                        n_state = S_PULL;
                    end
                end else begin
                    o_cmd.op = C_FINISH;
                    n_state = S_PULL;
                end
            end
            S_COPY_WR: begin
                o_cmd.op = C_COPY_WR;
                n_state = S_PULL;
            end
            S_OUT: begin
                // result moves to the output only once the old one is gone
                if (!r_ov || i_ready) begin
                    n_out = r_res;
                    n_ov = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov <= n_ov;
        end
        r_out <= n_out;
        r_res <= n_res;
    end

    assign o_valid = r_ov;
    assign o_data = r_out;
endmodule

// ===== hdl/lzss_rle_stream_decoder.sv =====
// Top level of the LZSS stream decoder with escape-coded run-length expansion
// Each request is a feed (one compressed byte into the 8-bit bit buffer) or a
// pull (run the decoder until one output byte, need-input, end or header
// error). Exactly one result comes back per request. A pull steps through
// each stream bit consumed, each field completion and, per copied byte, a
// window read, then a write-back. The window is a single-port-style memory
// of 2**MAX_WINDOW_BITS bytes with a registered read. Requests are handled
// one at a time; the result register holds an unaccepted result while the
// next request is still taken in.
module lzss_rle_stream_decoder #(
    parameter int MAX_WINDOW_BITS = lrd_pkg::MaxWindowBits
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  lrd_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output lrd_pkg::t_out o_data
);
    import lrd_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    lrd_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_data,
        .o_valid, .i_ready, .o_data, .o_cmd(cmd), .i_stat(stat)
    );

    lrd_datapath #(.MAX_WINDOW_BITS(MAX_WINDOW_BITS)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_stat(stat)
    );
endmodule

// ===== hdl/lrd_checker.sv =====
// Port-level checker for the stream decoder, bound to the top level
`include "lzss_rle_stream_decoder_defines.svh"
module lrd_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_ready,
    input lrd_pkg::t_in  i_data,
    input logic          o_valid,
    input logic          i_ready,
    input lrd_pkg::t_out o_data
);
    import lrd_pkg::*;

    `LRD_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_data), "result dropped while stalled")
    `LRD_ASSERT_IMP(a_status_range, i_clk, i_rst_n, o_valid, o_data.status <= ST_FEED_REJ, "status code out of range")
    `LRD_ASSERT_IMP(a_byte_zero, i_clk, i_rst_n, o_valid && o_data.status != ST_BYTE, o_data.out_byte == 8'd0, "byte nonzero without data status")
    `LRD_ASSERT_NXT(a_one_req, i_clk, i_rst_n, i_valid && o_ready, !o_ready, "second request taken while busy")
endmodule

bind lzss_rle_stream_decoder lrd_checker u_lrd_checker (
    .i_clk, .i_rst_n, .i_valid, .o_ready, .i_data, .o_valid, .i_ready, .o_data
);
